/* design/sos_pkg.sv */
// ----------------------------------------------------------------------------
// Sweep object segmenter package
// Shared types, register and command codes, slot reset values, and the
// tangent and cosine tables built from a fixed-point half-degree rotation.
// ----------------------------------------------------------------------------
package sos_pkg;

   localparam int MaxObjects = 5;

   localparam int TanLen = 180;
   localparam int TanW   = 19;
   localparam int CosLen = 91;
   localparam int CosW   = 13;

   localparam logic [63:0] RotC   = 64'd1073700939;
   localparam logic [63:0] RotS   = 64'd9370046;
   localparam logic [63:0] Half30 = 64'd536870912;

   localparam logic [1:0] CsrNearThreshold = 2'd0;
   localparam logic [1:0] CsrMinAngle      = 2'd1;
   localparam logic [1:0] CsrGoalRadius    = 2'd2;

   localparam logic CmdStart = 1'b0;
   localparam logic CmdStep  = 1'b1;

   localparam logic [11:0] NearThresholdReset = 12'd677;
   localparam logic [7:0]  MinAngleReset      = 8'd3;
   localparam logic [15:0] GoalRadiusReset    = 16'd112;

   localparam logic [7:0]  SlotAngleReset  = 8'd199;
   localparam logic [9:0]  SlotRangeReset  = 10'd99;
   localparam logic [15:0] SlotRadiusReset = 16'd1584;

   localparam logic [7:0]  FullTurn   = 8'd180;
   localparam logic [7:0]  RightAngle = 8'd90;
   localparam logic [10:0] MoveOffset = 11'd17;

   typedef struct packed {
      logic [7:0]  angle;
      logic [9:0]  range;
      logic [15:0] radius;
   } slot_type;

   typedef struct packed {
      logic [7:0]  sweep_angle;
      logic        ir_near;
      logic [2:0]  object_count;
      logic        new_object;
      logic [7:0]  new_object_angle;
      logic [9:0]  new_object_range;
      logic [15:0] new_object_radius;
      logic        sweep_done;
   } step_type;

   typedef struct packed {
      step_type    step;
      logic        goal_found;
      logic [2:0]  goal_index;
      logic [7:0]  goal_angle;
      logic [9:0]  goal_range;
   } goal_type;

   typedef struct packed {
      step_type    step;
      logic        goal_found;
      logic [2:0]  goal_index;
      logic        turn_left;
      logic [10:0] move_cm;
   } result_type;

   function automatic logic [63:0] rot_next_x(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] a;
      logic [63:0] b;
      a = x * RotC + Half30;
      b = y * RotS;
      rot_next_x = (a >= b) ? ((a - b) >> 30) : 64'd0;
   endfunction

   function automatic logic [63:0] rot_next_y(input logic [63:0] x, input logic [63:0] y);
      rot_next_y = (x * RotS + y * RotC + Half30) >> 30;
   endfunction

   function automatic logic [TanLen*TanW-1:0] build_tan_table();
      logic [63:0]             x;
      logic [63:0]             y;
      logic [63:0]             nx;
      logic [63:0]             num;
      logic [TanW-1:0]         q;
      logic [TanLen*TanW-1:0]  tbl;
      x   = 64'd1 << 30;
      y   = 64'd0;
      tbl = '0;
      for (int k = 0; k < TanLen; k++) begin
         num = (y << 12) + (x >> 1);
         q   = '0;
         for (int j = TanW - 1; j >= 0; j--) begin
            if (num >= (x << j)) begin
               num  = num - (x << j);
               q[j] = 1'b1;
            end
         end
         tbl[k*TanW +: TanW] = q;
         nx = rot_next_x(x, y);
         y  = rot_next_y(x, y);
         x  = nx;
      end
      return tbl;
   endfunction

   function automatic logic [CosLen*CosW-1:0] build_cos_table();
      logic [63:0]             x;
      logic [63:0]             y;
      logic [63:0]             nx;
      logic [63:0]             rounded;
      logic [CosLen*CosW-1:0]  tbl;
      x   = 64'd1 << 30;
      y   = 64'd0;
      tbl = '0;
      for (int k = 0; k < TanLen; k++) begin
         if ((k & 1) == 0) begin
            rounded = (x + 64'd131072) >> 18;
            tbl[(k >> 1)*CosW +: CosW] = rounded[CosW-1:0];
         end
         nx = rot_next_x(x, y);
         y  = rot_next_y(x, y);
         x  = nx;
      end
      return tbl;
   endfunction

   localparam logic [TanLen*TanW-1:0] TanTable = build_tan_table();
   localparam logic [CosLen*CosW-1:0] CosTable = build_cos_table();

   function automatic logic [TanW-1:0] tan_lookup(input logic [7:0] idx);
      tan_lookup = TanTable[idx*TanW +: TanW];
   endfunction

   function automatic logic [CosW-1:0] cos_lookup(input logic [6:0] idx);
      cos_lookup = CosTable[idx*CosW +: CosW];
   endfunction

endpackage

/* design/sweep_object_segmenter.sv */
// ----------------------------------------------------------------------------
// Sweep object segmenter: groups near IR readings of a sweep into objects.
// A request word is registered, then passes the step, goal search and move stages into the output queue.
// Throughput is one word per cycle while req_stall is low; an eight-entry output queue absorbs stalls.
// Synchronous reset restores the register defaults and clears the sweep state.
// ----------------------------------------------------------------------------
module sweep_object_segmenter #(
   parameter int SWEEP_END   = 180
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [15:0] req_ir_sum,
   input  logic [9:0]  req_sonar_cm,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_sweep_angle,
   output logic        rsp_ir_near,
   output logic [2:0]  rsp_object_count,
   output logic        rsp_new_object,
   output logic [7:0]  rsp_new_object_angle,
   output logic [9:0]  rsp_new_object_range,
   output logic [15:0] rsp_new_object_radius,
   output logic        rsp_sweep_done,
   output logic        rsp_goal_found,
   output logic [2:0]  rsp_goal_index,
   output logic        rsp_turn_left,
   output logic [10:0] rsp_move_cm
);

   localparam int CountW    = $clog2(sos_pkg::MaxObjects + 1);
   localparam int IdxW      = (sos_pkg::MaxObjects > 1) ? $clog2(sos_pkg::MaxObjects) : 1;
   localparam int FifoDepth = 8;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = FifoPtrW + 1;

   localparam logic [7:0]        SweepEnd = 8'(SWEEP_END);
   localparam logic [CountW-1:0] MaxCount = CountW'(sos_pkg::MaxObjects);

   logic [11:0] near_threshold_ff;
   logic [7:0]  min_angle_ff;
   logic [15:0] goal_radius_ff;

   logic        s0_valid_ff;
   logic        s0_command_ff;
   logic [15:0] s0_ir_sum_ff;
   logic [9:0]  s0_sonar_cm_ff;

   logic [7:0]        angle_ff;
   logic [7:0]        angle_in;
   logic              in_object_ff;
   logic              in_object_in;
   logic [7:0]        start_angle_ff;
   logic [7:0]        start_angle_in;
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic              finished_ff;
   logic              finished_in;
   sos_pkg::slot_type slot_ff [sos_pkg::MaxObjects];
   sos_pkg::slot_type slot_in [sos_pkg::MaxObjects];

   logic                  p1_valid_ff;
   sos_pkg::step_type     p1_step_ff;
   sos_pkg::step_type     p1_step_in;
   logic                  p2_valid_ff;
   sos_pkg::goal_type     p2_goal_ff;
   sos_pkg::goal_type     p2_goal_in;
   sos_pkg::result_type   result_in;

   sos_pkg::result_type   fifo_mem_ff [FifoDepth];
   logic [FifoPtrW-1:0]   wr_ptr_ff;
   logic [FifoPtrW-1:0]   rd_ptr_ff;
   logic [FifoCntW-1:0]   fifo_count_ff;
   logic [FifoCntW-1:0]   fifo_count_in;
   logic [FifoCntW-1:0]   inflight_ff;
   logic [FifoCntW-1:0]   inflight_in;

   logic                    req_accept;
   logic                    rsp_pop;
   logic [11:0]             ir_average;
   logic                    near;
   logic [7:0]              angle_step;
   logic                    counted;
   logic [7:0]              start_step;
   logic                    run_closed;
   logic                    record;
   logic [7:0]              span;
   logic [7:0]              tan_index;
   logic [sos_pkg::TanW-1:0] tan_value;
   logic [28:0]             radius_product;
   logic [15:0]             radius;
   logic                    goal_hit;
   logic [IdxW-1:0]         goal_slot;
   logic [6:0]              cos_index;
   logic [sos_pkg::CosW-1:0] cos_value;
   logic [22:0]             move_product;

   assign req_stall  = (inflight_ff >= FifoCntW'(FifoDepth));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (fifo_count_ff != '0);
   assign rsp_pop    = rsp_valid && !rsp_stall;

   // Step stage: the sweep state advances here, one word per cycle while requests are accepted.
   always_comb begin
      ir_average = s0_ir_sum_ff[15:4];
      near       = (ir_average >= near_threshold_ff);
      angle_step = (angle_ff < SweepEnd) ? angle_ff + 8'd1 : angle_ff;
      counted    = near && (angle_step > min_angle_ff);
      start_step = (counted && !in_object_ff) ? angle_step : start_angle_ff;
      run_closed = (in_object_ff || counted) && !near;
      record     = run_closed && (count_ff < MaxCount);
      span       = (angle_step >= start_step) ? angle_step - start_step : 8'd0;
      tan_index  = (span >= 8'(sos_pkg::TanLen)) ? 8'(sos_pkg::TanLen - 1) : span;
      tan_value  = sos_pkg::tan_lookup(tan_index);
      radius_product = 29'(s0_sonar_cm_ff) * 29'(tan_value);
      radius     = (|radius_product[28:23]) ? 16'hFFFF : radius_product[22:7];

      angle_in       = angle_ff;
      in_object_in   = in_object_ff;
      start_angle_in = start_angle_ff;
      count_in       = count_ff;
      finished_in    = finished_ff;
      for (int i = 0; i < sos_pkg::MaxObjects; i++) begin
         slot_in[i] = slot_ff[i];
      end
      p1_step_in = '0;

      if (s0_valid_ff) begin
         if (s0_command_ff == sos_pkg::CmdStart) begin
            angle_in       = '0;
            in_object_in   = 1'b0;
            start_angle_in = '0;
            count_in       = '0;
            finished_in    = 1'b0;
            for (int i = 0; i < sos_pkg::MaxObjects; i++) begin
               slot_in[i].angle  = sos_pkg::SlotAngleReset;
               slot_in[i].range  = sos_pkg::SlotRangeReset;
               slot_in[i].radius = sos_pkg::SlotRadiusReset;
            end
         end else begin
            angle_in       = angle_step;
            finished_in    = finished_ff || (angle_step >= SweepEnd);
            start_angle_in = start_step;
            in_object_in   = run_closed ? 1'b0 : (in_object_ff || counted);
            if (record) begin
               count_in = count_ff + CountW'(1);
            end
            for (int i = 0; i < sos_pkg::MaxObjects; i++) begin
               if (record && (count_ff == CountW'(i))) begin
                  slot_in[i].angle  = start_step;
                  slot_in[i].range  = s0_sonar_cm_ff;
                  slot_in[i].radius = radius;
               end
            end
            p1_step_in.sweep_angle  = angle_step;
            p1_step_in.ir_near      = near;
            p1_step_in.object_count = 3'(count_in);
            p1_step_in.new_object   = record;
            if (record) begin
               p1_step_in.new_object_angle  = start_step;
               p1_step_in.new_object_range  = s0_sonar_cm_ff;
               p1_step_in.new_object_radius = radius;
            end
            p1_step_in.sweep_done = finished_in;
         end
      end
   end

   // Goal search stage: the table registers hold exactly the state left by the
   // word in this stage, since the next word updates them only at this edge.
   always_comb begin
      goal_hit  = 1'b0;
      goal_slot = '0;
      for (int i = sos_pkg::MaxObjects - 1; i >= 0; i--) begin
         if (slot_ff[i].radius <= goal_radius_ff) begin
            goal_hit  = 1'b1;
            goal_slot = IdxW'(i);
         end
      end
      p2_goal_in      = '0;
      p2_goal_in.step = p1_step_ff;
      if (p1_step_ff.sweep_done && goal_hit) begin
         p2_goal_in.goal_found = 1'b1;
         p2_goal_in.goal_index = 3'(goal_slot);
         p2_goal_in.goal_angle = slot_ff[goal_slot].angle;
         p2_goal_in.goal_range = slot_ff[goal_slot].range;
      end
   end

   // Move stage: cosine projection of the goal range plus MoveOffset, and the turn direction.
   always_comb begin
      if (p2_goal_ff.goal_angle > sos_pkg::FullTurn) begin
         cos_index = '0;
      end else if (p2_goal_ff.goal_angle >= sos_pkg::RightAngle) begin
         cos_index = 7'(sos_pkg::FullTurn - p2_goal_ff.goal_angle);
      end else begin
         cos_index = 7'(p2_goal_ff.goal_angle);
      end
      cos_value    = sos_pkg::cos_lookup(cos_index);
      move_product = 23'(cos_value) * 23'(p2_goal_ff.goal_range);
      result_in      = '0;
      result_in.step = p2_goal_ff.step;
      if (p2_goal_ff.goal_found) begin
         result_in.goal_found = 1'b1;
         result_in.goal_index = p2_goal_ff.goal_index;
         result_in.turn_left  = (p2_goal_ff.goal_angle >= sos_pkg::RightAngle);
         result_in.move_cm    = move_product[22:12] + sos_pkg::MoveOffset;
      end
   end

   always_comb begin
      inflight_in   = inflight_ff + FifoCntW'(req_accept) - FifoCntW'(rsp_pop);
      fifo_count_in = fifo_count_ff + FifoCntW'(p2_valid_ff) - FifoCntW'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_threshold_ff <= sos_pkg::NearThresholdReset;
         min_angle_ff      <= sos_pkg::MinAngleReset;
         goal_radius_ff    <= sos_pkg::GoalRadiusReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sos_pkg::CsrNearThreshold: near_threshold_ff <= csr_wr_data[11:0];
            sos_pkg::CsrMinAngle:      min_angle_ff      <= csr_wr_data[7:0];
            sos_pkg::CsrGoalRadius:    goal_radius_ff    <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff       <= '0;
         in_object_ff   <= 1'b0;
         start_angle_ff <= '0;
         count_ff       <= '0;
         finished_ff    <= 1'b0;
         for (int i = 0; i < sos_pkg::MaxObjects; i++) begin
            slot_ff[i].angle  <= sos_pkg::SlotAngleReset;
            slot_ff[i].range  <= sos_pkg::SlotRangeReset;
            slot_ff[i].radius <= sos_pkg::SlotRadiusReset;
         end
      end else begin
         angle_ff       <= angle_in;
         in_object_ff   <= in_object_in;
         start_angle_ff <= start_angle_in;
         count_ff       <= count_in;
         finished_ff    <= finished_in;
         for (int i = 0; i < sos_pkg::MaxObjects; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
         inflight_ff   <= '0;
      end else begin
         s0_valid_ff   <= req_accept;
         p1_valid_ff   <= s0_valid_ff;
         p2_valid_ff   <= p1_valid_ff;
         fifo_count_ff <= fifo_count_in;
         inflight_ff   <= inflight_in;
         if (p2_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + FifoPtrW'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FifoPtrW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      s0_command_ff  <= req_command;
      s0_ir_sum_ff   <= req_ir_sum;
      s0_sonar_cm_ff <= req_sonar_cm;
      p1_step_ff     <= p1_step_in;
      p2_goal_ff     <= p2_goal_in;
      if (p2_valid_ff) begin
         fifo_mem_ff[wr_ptr_ff] <= result_in;
      end
   end

   assign rsp_sweep_angle       = fifo_mem_ff[rd_ptr_ff].step.sweep_angle;
   assign rsp_ir_near           = fifo_mem_ff[rd_ptr_ff].step.ir_near;
   assign rsp_object_count      = fifo_mem_ff[rd_ptr_ff].step.object_count;
   assign rsp_new_object        = fifo_mem_ff[rd_ptr_ff].step.new_object;
   assign rsp_new_object_angle  = fifo_mem_ff[rd_ptr_ff].step.new_object_angle;
   assign rsp_new_object_range  = fifo_mem_ff[rd_ptr_ff].step.new_object_range;
   assign rsp_new_object_radius = fifo_mem_ff[rd_ptr_ff].step.new_object_radius;
   assign rsp_sweep_done        = fifo_mem_ff[rd_ptr_ff].step.sweep_done;
   assign rsp_goal_found        = fifo_mem_ff[rd_ptr_ff].goal_found;
   assign rsp_goal_index        = fifo_mem_ff[rd_ptr_ff].goal_index;
   assign rsp_turn_left         = fifo_mem_ff[rd_ptr_ff].turn_left;
   assign rsp_move_cm           = fifo_mem_ff[rd_ptr_ff].move_cm;

   // Every accepted word is either in a pipeline stage or in the output queue.
   a_inflight_tracks_pipeline: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == fifo_count_ff + FifoCntW'(s0_valid_ff) + FifoCntW'(p1_valid_ff)
                     + FifoCntW'(p2_valid_ff))
      else $error("In-flight count disagrees with pipeline and queue occupancy.");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount)
      else $error("Object count exceeds the table size.");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && (s0_command_ff == sos_pkg::CmdStart)) |=>
         (count_ff == '0 && !in_object_ff && angle_ff == '0 && !finished_ff))
      else $error("Start command did not clear the sweep state.");

   a_goal_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_goal_found || rsp_sweep_done))
      else $error("Goal reported before the sweep finished.");

endmodule
